// ===== rtl/core/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 string validator.
`default_nettype none

package utf8v_pkg;

  localparam int unsigned CountW = 12;
  localparam int unsigned DefaultLengthLimit = 4095;
  localparam logic [CountW-1:0] MaxBytesReset = 12'd80;
  localparam logic AllowEmptyReset = 1'b0;

  typedef enum logic [2:0] {
    ErrOk      = 3'd0,
    ErrEmpty   = 3'd1,
    ErrLong    = 3'd2,
    ErrControl = 3'd3,
    ErrLead    = 3'd4,
    ErrCont    = 3'd5,
    ErrTrunc   = 3'd6,
    ErrRange   = 3'd7
  } err_e;

  typedef enum logic {
    CfgMaxBytes   = 1'b0,
    CfgAllowEmpty = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [2:0]        error_code;
    logic [CountW-1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              overflow;
    logic [1:0]        pending;
    logic [20:0]       codepoint;
    logic [7:0]        lead;
    err_e              first_error;
  } str_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/utf8v_step.sv =====
// Per-byte state update and end-of-string verdict of the UTF-8 validator.
`default_nettype none

module utf8v_step import utf8v_pkg::*; #(
  parameter int unsigned LengthLimit = DefaultLengthLimit
) (
  input  str_state_t        state_i,
  input  in_item_t          item_i,
  input  logic [CountW-1:0] max_bytes_i,
  input  logic              allow_empty_i,
  output str_state_t        state_o,
  output logic              res_valid_o,
  output out_item_t         res_o
);

  localparam logic [CountW-1:0] CountCap =
    (LengthLimit > 4095) ? 12'd4095 : CountW'(LengthLimit);

  str_state_t upd;
  logic [7:0]  b;
  logic [20:0] cp_nxt;
  logic [1:0]  pend_dec;
  err_e        code;

  assign b        = item_i.data_byte;
  assign cp_nxt   = {state_i.codepoint[14:0], b[5:0]};
  assign pend_dec = state_i.pending - 2'd1;

  always_comb begin
    upd = state_i;
    if (state_i.count < CountCap) begin
      upd.count = state_i.count + 12'd1;
    end else begin
      upd.overflow = 1'b1;
    end

    if (state_i.first_error != ErrOk) begin
      if (state_i.first_error == ErrCont && state_i.pending != 2'd0) begin
        upd.pending = pend_dec;
      end
    end else if (state_i.pending == 2'd0) begin
      if (b < 8'h80) begin
        if (b < 8'h20 || b == 8'h7f) begin
          upd.first_error = ErrControl;
        end
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        upd.pending   = 2'd1;
        upd.codepoint = {16'd0, b[4:0]};
        upd.lead      = b;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        upd.pending   = 2'd2;
        upd.codepoint = {17'd0, b[3:0]};
        upd.lead      = b;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        upd.pending   = 2'd3;
        upd.codepoint = {18'd0, b[2:0]};
        upd.lead      = b;
      end else begin
        upd.first_error = ErrLead;
      end
    end else begin
      upd.pending = pend_dec;
      if (b[7:6] != 2'b10) begin
        upd.first_error = ErrCont;
      end else begin
        upd.codepoint = cp_nxt;
        if (pend_dec == 2'd0) begin
          if ((state_i.lead == 8'he0 && cp_nxt < 21'h800) ||
              (state_i.lead == 8'hed && cp_nxt >= 21'hd800) ||
              (state_i.lead == 8'hf0 && cp_nxt < 21'h10000) ||
              cp_nxt > 21'h10ffff) begin
            upd.first_error = ErrRange;
          end
        end
      end
    end

    if (upd.overflow || upd.count > max_bytes_i) begin
      code = ErrLong;
    end else if ((upd.first_error == ErrOk || upd.first_error == ErrCont) &&
                 upd.pending != 2'd0) begin
      code = ErrTrunc;
    end else begin
      code = upd.first_error;
    end

    state_o     = upd;
    res_valid_o = 1'b0;
    res_o       = '{valid_res: (code == ErrOk), error_code: code, byte_count: upd.count};

    if (item_i.empty_string) begin
      state_o     = '0;
      res_valid_o = 1'b1;
      res_o       = '{valid_res: allow_empty_i,
                      error_code: (allow_empty_i ? ErrOk : ErrEmpty),
                      byte_count: '0};
    end else if (item_i.last_byte) begin
      state_o     = '0;
      res_valid_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_string_validator.sv =====
// Top level of the UTF-8 string validator: input register, string state and result register.
`default_nettype none

// The block takes one string byte per transaction and can accept a new byte in every
// clock cycle while the input register is not stalled. Each byte is captured in an input
// register, then checked and folded into the string state, and a verdict is written to
// the result register when the byte marks the end of the string. The input register
// stalls only while a verdict waits in the result register and the byte behind it would
// produce another one. Configuration registers may be written only while no string is
// in flight.
module utf8_string_validator import utf8v_pkg::*; #(
  parameter int unsigned LengthLimit = DefaultLengthLimit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_o
);

  logic [CountW-1:0] max_bytes_q;
  logic              allow_empty_q;
  logic              in_valid_q;
  in_item_t          in_q;
  str_state_t        state_q, state_d;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              res_valid;
  out_item_t         res;
  logic              out_free;
  logic              advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q   <= MaxBytesReset;
      allow_empty_q <= AllowEmptyReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMaxBytes:   max_bytes_q   <= cfg_wdata_i;
        CfgAllowEmpty: allow_empty_q <= cfg_wdata_i[0];
        default:       max_bytes_q   <= max_bytes_q;
      endcase
    end
  end

  utf8v_step #(
    .LengthLimit(LengthLimit)
  ) u_step (
    .state_i      (state_q),
    .item_i       (in_q),
    .max_bytes_i  (max_bytes_q),
    .allow_empty_i(allow_empty_q),
    .state_o      (state_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= advance && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (out_free && advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_verdict_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.valid_res == (out_o.error_code == ErrOk)))
    else $error("verdict bit disagrees with error code");

  a_empty_has_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.error_code == ErrEmpty) |-> (out_o.byte_count == '0))
    else $error("empty string verdict carries a byte count");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && res_valid && out_valid_q && !out_ready_i))
    else $error("result produced while result register is stalled");

  a_pending_only_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending != 2'd0) |->
      (state_q.first_error == ErrOk || state_q.first_error == ErrCont))
    else $error("open sequence after a non-continuation error");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

// ===== sim/utf8_string_validator_test.sv =====
// Self-checking testbench for the UTF-8 string validator: directed table, random strings, idling.
module utf8_string_validator_test;
  import utf8v_pkg::*;

  localparam int unsigned CountCap = DefaultLengthLimit > 4095 ? 4095 : DefaultLengthLimit;
  localparam int unsigned CycleLimit = 500000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t verdict;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_o;

  logic [CountW-1:0] str_count;
  logic              str_ovf;
  logic [1:0]        str_pend;
  logic [20:0]       str_cp;
  logic [7:0]        str_lead;
  err_e              str_err;
  logic [CountW-1:0] lim_bytes;
  logic              empty_ok;

  out_item_t   pending_verdicts[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  int          items_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{'{8'hff, 1'b1, 1'b1}, 1'b1, '{1'b0, ErrEmpty, 12'd0}},
    '{'{8'h41, 1'b1, 1'b0}, 1'b1, '{1'b1, ErrOk, 12'd1}},
    '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{1'b0, ErrControl, 12'd1}},
    '{'{8'h7f, 1'b1, 1'b0}, 1'b1, '{1'b0, ErrControl, 12'd1}},
    '{'{8'h80, 1'b1, 1'b0}, 1'b1, '{1'b0, ErrLead, 12'd1}},
    '{'{8'hff, 1'b1, 1'b0}, 1'b1, '{1'b0, ErrLead, 12'd1}},
    '{'{8'hc2, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'he0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h9f, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hbf, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hed, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'ha0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hf4, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'he2, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hc3, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h61, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, ErrEmpty, 12'd0}}
  };

  utf8_string_validator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void clear_string();
    str_count = '0;
    str_ovf   = 1'b0;
    str_pend  = '0;
    str_cp    = '0;
    str_lead  = '0;
    str_err   = ErrOk;
  endfunction

  // Folds one transaction into the string state; returns 1 when it yields a verdict.
  function automatic bit advance_string(input in_item_t it, output out_item_t verdict);
    err_e code;
    verdict = '0;
    if (it.empty_string) begin
      clear_string();
      code = empty_ok ? ErrOk : ErrEmpty;
      verdict.valid_res  = (code == ErrOk);
      verdict.error_code = code;
      return 1'b1;
    end
    if (str_count < CountCap) str_count++;
    else str_ovf = 1'b1;
    if (str_err != ErrOk) begin
      if (str_err == ErrCont && str_pend != 0) str_pend--;
    end else if (str_pend == 0) begin
      if (it.data_byte < 8'h80) begin
        if (it.data_byte < 8'h20 || it.data_byte == 8'h7f) str_err = ErrControl;
      end else if (it.data_byte inside {[8'hc2:8'hdf]}) begin
        str_pend = 2'd1;
        str_cp   = {16'd0, it.data_byte[4:0]};
        str_lead = it.data_byte;
      end else if (it.data_byte inside {[8'he0:8'hef]}) begin
        str_pend = 2'd2;
        str_cp   = {17'd0, it.data_byte[3:0]};
        str_lead = it.data_byte;
      end else if (it.data_byte inside {[8'hf0:8'hf4]}) begin
        str_pend = 2'd3;
        str_cp   = {18'd0, it.data_byte[2:0]};
        str_lead = it.data_byte;
      end else begin
        str_err = ErrLead;
      end
    end else begin
      str_pend--;
      if (it.data_byte[7:6] != 2'b10) begin
        str_err = ErrCont;
      end else begin
        str_cp = {str_cp[14:0], it.data_byte[5:0]};
        if (str_pend == 0 && ((str_lead == 8'he0 && str_cp < 21'h800) ||
                              (str_lead == 8'hed && str_cp >= 21'hd800) ||
                              (str_lead == 8'hf0 && str_cp < 21'h10000) ||
                              str_cp > 21'h10ffff)) begin
          str_err = ErrRange;
        end
      end
    end
    if (!it.last_byte) return 1'b0;
    if (str_ovf || str_count > lim_bytes) code = ErrLong;
    else if ((str_err == ErrOk || str_err == ErrCont) && str_pend != 0) code = ErrTrunc;
    else code = str_err;
    verdict.valid_res  = (code == ErrOk);
    verdict.error_code = code;
    verdict.byte_count = str_count;
    clear_string();
    return 1'b1;
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t typed_v);
    out_item_t v;
    bit        has;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    has = advance_string(it, v);
    if (has) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMaxBytes) lim_bytes = value;
    else empty_ok = value[0];
  endtask

  task automatic send_random_string();
    logic [7:0] bytes[$];
    in_item_t   it;
    int         n_chars;
    int         n_cont;
    int         r;
    bit         abort;
    if ($urandom_range(99) < 5) begin
      it.data_byte    = 8'($urandom_range(255));
      it.last_byte    = 1'($urandom_range(1));
      it.empty_string = 1'b1;
      push_item(it, 1'b0, '0);
      return;
    end
    n_chars = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(20, 60);
    repeat (n_chars) begin
      r = $urandom_range(99);
      n_cont = 0;
      if (r < 8) begin
        bytes.push_back(8'($urandom_range(255)));
      end else if (r < 55) begin
        bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end else if (r < 70) begin
        bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
        n_cont = 1;
      end else if (r < 88) begin
        bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
        n_cont = 2;
      end else begin
        bytes.push_back(8'($urandom_range(8'hf0, 8'hf4)));
        n_cont = 3;
      end
      repeat (n_cont) bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
    end
    if ($urandom_range(99) < 8 && bytes.size() > 1) void'(bytes.pop_back());
    abort = ($urandom_range(99) < 4);
    foreach (bytes[k]) begin
      it.data_byte    = bytes[k];
      it.last_byte    = !abort && (k == bytes.size() - 1);
      it.empty_string = 1'b0;
      push_item(it, 1'b0, '0);
    end
    if (abort) begin
      it.data_byte    = 8'($urandom_range(255));
      it.last_byte    = 1'($urandom_range(1));
      it.empty_string = 1'b1;
      push_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [CountW-1:0] max_bytes, input logic allow,
                           input int s_pct, input int r_pct, input int budget,
                           input bit squeeze);
    write_reg(CfgMaxBytes, max_bytes);
    write_reg(CfgAllowEmpty, {{(CountW-1){1'b0}}, allow});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (squeeze) hold_req = 1'b1;
    items_sent = 0;
    while (items_sent < budget) send_random_string();
    drain();
  endtask

  initial begin
    bit hold_taken;
    int hold_left;
    hold_taken  = 1'b0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transaction with no verdict expected: %h", out_o);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_o.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, out_o.valid_res);
          mismatches++;
        end
        if (out_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_o.error_code);
          mismatches++;
        end
        if (out_o.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, out_o.byte_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgMaxBytes;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_i          = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    lim_bytes     = MaxBytesReset;
    empty_ok      = AllowEmptyReset;
    clear_string();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].verdict);
    drain();

    run_phase(12'd4095, 1'b1, 35, 62, 230, 1'b0);
    run_phase(12'd0, 1'b1, 62, 35, 50, 1'b0);
    run_phase(12'($urandom_range(1, 60)), 1'b0, 62, 35, 200, 1'b0);
    run_phase(12'd4095, 1'b0, 0, 0, 220, 1'b1);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
